@@ hdl/hbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants for the linear-probing hash table with backward-shift drop.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int SLOT_BITS_DEFAULT        = 8;
   localparam int VALUES_PER_ENTRY_DEFAULT = 4;

   localparam logic [31:0] MULT_HASH = 32'd2654435761;

   localparam logic [1:0] OP_GET  = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_DROP = 2'd2;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_REJECT   = 3'd4;

endpackage

@@ hdl/hbs_key_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_key_mem
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hbs_key_mem #(
   parameter int SLOT_BITS = hbs_pkg::SLOT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  logic [31:0]          wr_data,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic [31:0]          rd_data
);

   logic [31:0] mem [(1 << SLOT_BITS)];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/hbs_val_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_val_mem
// Value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hbs_val_mem #(
   parameter int ADDR_W = 10,
   parameter int DEPTH  = 1024
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/hash_table_backward_shift_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_backward_shift_top
// Open-addressed key/value table, linear probing, backward-shift delete.
// ----------------------------------------------------------------------------
// After reset the key store is swept to empty, one slot per cycle, over all
// 2^SLOT_BITS slots; no request is taken during the sweep. One request is
// worked at a time. A request goes through decode and home-slot setup, then
// one key memory read followed by a compare for each probed slot; a get hit
// adds one value read, an insert adds VALUES_PER_ENTRY value writes, and a
// drop adds a key read, a hash and a home compare for each slot scanned
// during cluster repair plus a key move and VALUES_PER_ENTRY value copies per
// moved entry (each copy is a read then a write of the single value memory).
// The result sits in an output register so a new request is taken while it
// waits.
// ----------------------------------------------------------------------------
module hash_table_backward_shift_top #(
   parameter int SLOT_BITS        = hbs_pkg::SLOT_BITS_DEFAULT,
   parameter int VALUES_PER_ENTRY = hbs_pkg::VALUES_PER_ENTRY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key,
   input  logic [3:0]  req_param_index,
   input  logic [15:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_value,
   output logic [2:0]  rsp_status,
   output logic [8:0]  rsp_live_count,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   localparam int NSLOTS = 1 << SLOT_BITS;
   localparam int CNT_W  = SLOT_BITS + 1;
   localparam int VDEPTH = NSLOTS * VALUES_PER_ENTRY;
   localparam int VAW    = $clog2(VDEPTH);
   localparam int SB     = SLOT_BITS;

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_DEC  = 5'd2;
   localparam logic [4:0] S_HOME = 5'd3;
   localparam logic [4:0] S_PRD  = 5'd4;
   localparam logic [4:0] S_PCHK = 5'd5;
   localparam logic [4:0] S_VGET = 5'd6;
   localparam logic [4:0] S_INS  = 5'd7;
   localparam logic [4:0] S_SNXT = 5'd8;
   localparam logic [4:0] S_SCHK = 5'd9;
   localparam logic [4:0] S_SCMP = 5'd10;
   localparam logic [4:0] S_SMV  = 5'd11;
   localparam logic [4:0] S_CRD  = 5'd12;
   localparam logic [4:0] S_CWR  = 5'd13;
   localparam logic [4:0] S_DONE = 5'd14;

   logic [4:0]     state_ff, state_in;
   logic [1:0]     op_ff, op_in;
   logic [31:0]    key_ff, key_in;
   logic [3:0]     pi_ff, pi_in;
   logic [15:0]    wv_ff, wv_in;
   logic [31:0]    prod_ff, prod_in;
   logic [SB-1:0]  slot_ff, slot_in;
   logic [SB-1:0]  hole_ff, hole_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [1:0]     p_ff, p_in;
   logic [31:0]    kj_ff, kj_in;
   logic [15:0]    rd_ff, rd_in;
   logic [2:0]     st_ff, st_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [63:0]    dflt_ff, dflt_in;
   logic [CNT_W-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_rd_ff, rsp_rd_in;
   logic [2:0]     rsp_st_ff, rsp_st_in;
   logic [8:0]     rsp_live_ff, rsp_live_in;

   logic           k_we;
   logic [SB-1:0]  k_waddr, k_raddr;
   logic [31:0]    k_wdata, k_rdata;
   logic           v_we;
   logic [VAW-1:0] v_waddr, v_raddr;
   logic [15:0]    v_wdata, v_rdata;

   logic [15:0]    dflt_pi, dflt_p;
   logic [SB-1:0]  h_slot, j_next;
   logic [CNT_W+8:0] live_ext;

   hbs_key_mem #(.SLOT_BITS(SLOT_BITS)) u_key_mem (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (k_wdata),
      .rd_addr (k_raddr),
      .rd_data (k_rdata)
   );

   hbs_val_mem #(.ADDR_W(VAW), .DEPTH(VDEPTH)) u_val_mem (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   function automatic logic [VAW-1:0] vaddr(input logic [SB-1:0] s, input logic [1:0] p);
      vaddr = VAW'(VAW'(s) * VAW'(VALUES_PER_ENTRY) + VAW'(p));
   endfunction

   assign dflt_pi  = dflt_ff[pi_ff[1:0]*16 +: 16];
   assign dflt_p   = dflt_ff[p_ff*16 +: 16];
   assign h_slot   = prod_ff[31:32-SB];
   assign j_next   = slot_ff + SB'(1);
   assign live_ext = (CNT_W+9)'(live_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pi_in        = pi_ff;
      wv_in        = wv_ff;
      prod_in      = prod_ff;
      slot_in      = slot_ff;
      hole_in      = hole_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      kj_in        = kj_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      live_in      = live_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_live_in  = rsp_live_ff;
      dflt_in      = csr_write_enable ? csr_write_data : dflt_ff;
      k_we         = 1'b0;
      k_waddr      = slot_ff;
      k_wdata      = 32'd0;
      k_raddr      = slot_ff;
      v_we         = 1'b0;
      v_waddr      = vaddr(slot_ff, pi_ff[1:0]);
      v_wdata      = wv_ff;
      v_raddr      = vaddr(slot_ff, pi_ff[1:0]);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            k_we    = 1'b1;
            k_waddr = clr_ff[SB-1:0];
            clr_in  = clr_ff + CNT_W'(1);
            if (clr_ff == CNT_W'(NSLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               key_in   = req_key;
               pi_in    = req_param_index;
               wv_in    = req_write_value;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rd_in    = 16'd0;
            st_in    = hbs_pkg::ST_REJECT;
            state_in = S_DONE;
            prod_in  = 32'(key_ff * hbs_pkg::MULT_HASH);
            case (op_ff)
               hbs_pkg::OP_GET: begin
                  if (pi_ff < 4'(VALUES_PER_ENTRY)) begin
                     rd_in = dflt_pi;
                     if (key_ff != 32'd0) begin
                        st_in = hbs_pkg::ST_MISS;
                        if (live_ff != '0) begin
                           state_in = S_HOME;
                        end
                     end
                  end
               end
               hbs_pkg::OP_SET: begin
                  if (pi_ff < 4'(VALUES_PER_ENTRY) && key_ff != 32'd0) begin
                     state_in = S_HOME;
                  end
               end
               hbs_pkg::OP_DROP: begin
                  if (key_ff != 32'd0) begin
                     st_in = hbs_pkg::ST_MISS;
                     if (live_ff != '0) begin
                        state_in = S_HOME;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_HOME: begin
            slot_in  = h_slot;
            n_in     = '0;
            state_in = S_PRD;
         end
         S_PRD: begin
            k_raddr  = slot_ff;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (k_rdata == 32'd0) begin
               if (op_ff == hbs_pkg::OP_SET) begin
                  k_we     = 1'b1;
                  k_waddr  = slot_ff;
                  k_wdata  = key_ff;
                  p_in     = 2'd0;
                  state_in = S_INS;
               end else begin
                  st_in    = hbs_pkg::ST_MISS;
                  state_in = S_DONE;
               end
            end else if (k_rdata == key_ff) begin
               st_in = hbs_pkg::ST_HIT;
               if (op_ff == hbs_pkg::OP_GET) begin
                  v_raddr  = vaddr(slot_ff, pi_ff[1:0]);
                  state_in = S_VGET;
               end else if (op_ff == hbs_pkg::OP_SET) begin
                  v_we     = 1'b1;
                  v_waddr  = vaddr(slot_ff, pi_ff[1:0]);
                  v_wdata  = wv_ff;
                  state_in = S_DONE;
               end else begin
                  k_we     = 1'b1;
                  k_waddr  = slot_ff;
                  k_wdata  = 32'd0;
                  live_in  = live_ff - CNT_W'(1);
                  hole_in  = slot_ff;
                  n_in     = '0;
                  state_in = S_SNXT;
               end
            end else begin
               n_in    = n_ff + CNT_W'(1);
               slot_in = j_next;
               if (n_ff + CNT_W'(1) == CNT_W'(NSLOTS)) begin
                  st_in    = (op_ff == hbs_pkg::OP_SET) ? hbs_pkg::ST_FULL
                                                        : hbs_pkg::ST_MISS;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PRD;
               end
            end
         end
         S_VGET: begin
            rd_in    = v_rdata;
            state_in = S_DONE;
         end
         S_INS: begin
            v_we    = 1'b1;
            v_waddr = vaddr(slot_ff, p_ff);
            v_wdata = (p_ff == pi_ff[1:0]) ? wv_ff : dflt_p;
            p_in    = p_ff + 2'd1;
            if (p_ff == 2'(VALUES_PER_ENTRY - 1)) begin
               live_in  = live_ff + CNT_W'(1);
               st_in    = hbs_pkg::ST_INSERTED;
               state_in = S_DONE;
            end
         end
         S_SNXT: begin
            if (n_ff == CNT_W'(NSLOTS)) begin
               state_in = S_DONE;
            end else begin
               k_raddr  = j_next;
               slot_in  = j_next;
               n_in     = n_ff + CNT_W'(1);
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (k_rdata == 32'd0) begin
               state_in = S_DONE;
            end else begin
               kj_in    = k_rdata;
               prod_in  = 32'(k_rdata * hbs_pkg::MULT_HASH);
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (SB'(slot_ff - h_slot) < SB'(slot_ff - hole_ff)) begin
               state_in = S_SNXT;
            end else begin
               k_we     = 1'b1;
               k_waddr  = hole_ff;
               k_wdata  = kj_ff;
               state_in = S_SMV;
            end
         end
         S_SMV: begin
            k_we     = 1'b1;
            k_waddr  = slot_ff;
            k_wdata  = 32'd0;
            p_in     = 2'd0;
            state_in = S_CRD;
         end
         S_CRD: begin
            v_raddr  = vaddr(slot_ff, p_ff);
            state_in = S_CWR;
         end
         S_CWR: begin
            v_we    = 1'b1;
            v_waddr = vaddr(hole_ff, p_ff);
            v_wdata = v_rdata;
            p_in    = p_ff + 2'd1;
            if (p_ff == 2'(VALUES_PER_ENTRY - 1)) begin
               hole_in  = slot_ff;
               state_in = S_SNXT;
            end else begin
               state_in = S_CRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = (op_ff == hbs_pkg::OP_GET) ? rd_ff : 16'd0;
               rsp_st_in    = st_ff;
               rsp_live_in  = live_ext[8:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         live_ff      <= '0;
         dflt_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pi_ff       <= pi_in;
      wv_ff       <= wv_in;
      prod_ff     <= prod_in;
      slot_ff     <= slot_in;
      hole_ff     <= hole_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      kj_ff       <= kj_in;
      rd_ff       <= rd_in;
      st_ff       <= st_in;
      rsp_rd_ff   <= rsp_rd_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_live_ff <= rsp_live_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule

@@ bench/hash_table_backward_shift_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_backward_shift_checker
// Watches the request, response and register ports of the hash table. Keeps
// its own copy of the keys, values and default vector, predicts each response
// as a request beat is taken, and compares responses in order.
// ----------------------------------------------------------------------------
module hash_table_backward_shift_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key,
   input  logic [3:0]  req_param_index,
   input  logic [15:0] req_write_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_read_value,
   input  logic [2:0]  rsp_status,
   input  logic [8:0]  rsp_live_count,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen
);

   localparam int NSLOTS = 256;
   localparam int NVALS  = 4;

   typedef struct packed {
      logic [15:0] read_value;
      logic [2:0]  status;
      logic [8:0]  live_count;
   } table_rsp_type;

   table_rsp_type expected_rsp_q[$];
   logic [63:0]   default_vec;
   logic [31:0]   key_mem[NSLOTS];
   logic [15:0]   val_mem[NSLOTS*NVALS];
   int            live;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_seen   = 0;
   end

   function automatic int home_of(logic [31:0] k);
      logic [31:0] p;
      p = k * hbs_pkg::MULT_HASH;
      return int'(p[31:24]);
   endfunction

   function automatic logic [15:0] default_at(int p);
      return default_vec[16*(p&3) +: 16];
   endfunction

   function automatic int lookup(logic [31:0] k);
      int s;
      s = home_of(k);
      for (int n = 0; n < NSLOTS; n++) begin
         if (key_mem[s] == 0) return NSLOTS;
         if (key_mem[s] == k) return s;
         s = (s + 1) & (NSLOTS - 1);
      end
      return NSLOTS;
   endfunction

   function automatic void unlink(int hole);
      int j;
      int h;
      j = hole;
      key_mem[hole] = 0;
      live--;
      for (int n = 0; n < NSLOTS; n++) begin
         j = (j + 1) & (NSLOTS - 1);
         if (key_mem[j] == 0) return;
         h = home_of(key_mem[j]);
         if (((j - h) & (NSLOTS - 1)) < ((j - hole) & (NSLOTS - 1))) continue;
         key_mem[hole] = key_mem[j];
         for (int p = 0; p < NVALS; p++) val_mem[hole*NVALS+p] = val_mem[j*NVALS+p];
         key_mem[j] = 0;
         hole = j;
      end
   endfunction

   function automatic int place(logic [31:0] k);
      int s;
      s = home_of(k);
      if (live >= NSLOTS) return NSLOTS;
      for (int n = 0; n < NSLOTS; n++) begin
         if (key_mem[s] == 0) begin
            key_mem[s] = k;
            for (int p = 0; p < NVALS; p++) val_mem[s*NVALS+p] = default_at(p);
            live++;
            return s;
         end
         s = (s + 1) & (NSLOTS - 1);
      end
      return NSLOTS;
   endfunction

   function automatic table_rsp_type apply_request(logic [1:0] op, logic [31:0] k,
                                                   logic [3:0] idx, logic [15:0] wv);
      table_rsp_type r;
      int s;
      r.read_value = '0;
      r.status     = hbs_pkg::ST_REJECT;
      case (op)
         hbs_pkg::OP_GET: begin
            if (idx < NVALS) begin
               if (k == 0) begin
                  r.read_value = default_at(idx);
               end else begin
                  s = live ? lookup(k) : NSLOTS;
                  if (s < NSLOTS) begin
                     r.read_value = val_mem[s*NVALS+idx];
                     r.status     = hbs_pkg::ST_HIT;
                  end else begin
                     r.read_value = default_at(idx);
                     r.status     = hbs_pkg::ST_MISS;
                  end
               end
            end
         end
         hbs_pkg::OP_SET: begin
            if (idx < NVALS && k != 0) begin
               s = lookup(k);
               if (s < NSLOTS) begin
                  r.status = hbs_pkg::ST_HIT;
               end else begin
                  s = place(k);
                  r.status = (s < NSLOTS) ? hbs_pkg::ST_INSERTED : hbs_pkg::ST_FULL;
               end
               if (s < NSLOTS) val_mem[s*NVALS+idx] = wv;
            end
         end
         hbs_pkg::OP_DROP: begin
            if (k != 0) begin
               s = live ? lookup(k) : NSLOTS;
               if (s < NSLOTS) begin
                  unlink(s);
                  r.status = hbs_pkg::ST_HIT;
               end else begin
                  r.status = hbs_pkg::ST_MISS;
               end
            end
         end
         default: ;
      endcase
      r.live_count = 9'(live);
      return r;
   endfunction

   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         default_vec = '0;
         for (int i = 0; i < NSLOTS; i++) key_mem[i] = 0;
         for (int i = 0; i < NSLOTS*NVALS; i++) val_mem[i] = 0;
         live = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_write_enable) default_vec = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value expected %0h got %0h", want.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_live_count !== want.live_count) begin
                  $error("live_count expected %0d got %0d", want.live_count, rsp_live_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_request(req_operation, req_key,
                                                   req_param_index, req_write_value));
      end
      pending = expected_rsp_q.size();
   end

endmodule

@@ bench/hash_table_backward_shift_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_backward_shift_top_tb
// Drives gets, sets and drops into the hash table under changing defaults and
// handshake stalls, including a full-table fill and drain; the checker module
// predicts and compares every response beat.
// ----------------------------------------------------------------------------
module hash_table_backward_shift_top_tb;

   localparam int STALL_LIMIT = 50000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [31:0] req_key;
   logic [3:0]  req_param_index;
   logic [15:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_read_value;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_live_count;
   logic        csr_write_enable;
   logic [63:0] csr_write_data;

   int          fail_count;
   int          pending;
   int          rsp_seen;
   int          send_idle;
   int          recv_idle;
   int          quiet_cycles = 0;
   int          req_sent;
   logic [31:0] key_pool[48];

   hash_table_backward_shift_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_param_index  (req_param_index),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   hash_table_backward_shift_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_param_index  (req_param_index),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .rsp_seen         (rsp_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(logic [1:0] op, logic [31:0] k, logic [3:0] idx, logic [15:0] wv);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_key         <= k;
      req_param_index <= idx;
      req_write_value <= wv;
      req_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_defaults(logic [63:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_beats(int count);
      int          pick;
      logic [31:0] k;
      logic [3:0]  idx;
      for (int i = 0; i < 48; i++) key_pool[i] = $urandom() | 32'h1;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         k    = key_pool[$urandom_range(47)];
         idx  = 4'($urandom_range(3));
         if (pick < 45)      send(hbs_pkg::OP_SET, k, idx, 16'($urandom()));
         else if (pick < 72) send(hbs_pkg::OP_GET, k, idx, 16'($urandom()));
         else if (pick < 92) send(hbs_pkg::OP_DROP, k, 4'($urandom()), 16'($urandom()));
         else                send(2'($urandom()), ($urandom_range(1) ? 32'h0 : $urandom()),
                                  4'($urandom()), 16'($urandom()));
      end
   endtask

   task automatic fill_and_drain();
      logic [31:0] fill_keys[256];
      int          j;
      logic [31:0] t;
      for (int i = 0; i < 256; i++) begin
         fill_keys[i] = {24'($urandom()) | 24'h1, 8'(i)};
         send(hbs_pkg::OP_SET, fill_keys[i], 4'($urandom_range(3)), 16'($urandom()));
      end
      send(hbs_pkg::OP_SET, 32'hDEAD_0001, 4'd0, 16'h1234);
      send(hbs_pkg::OP_SET, fill_keys[7], 4'd2, 16'hBEEF);
      send(hbs_pkg::OP_GET, 32'hDEAD_0001, 4'd1, 16'h0);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         t = fill_keys[i];
         fill_keys[i] = fill_keys[j];
         fill_keys[j] = t;
      end
      for (int i = 0; i < 256; i++) begin
         send(hbs_pkg::OP_DROP, fill_keys[i], 4'($urandom()), 16'h0);
         if ((i & 15) == 0)
            send(hbs_pkg::OP_GET, fill_keys[$urandom_range(255)], 4'($urandom_range(3)),
                 16'h0);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= hbs_pkg::OP_GET;
      req_key          <= '0;
      req_param_index  <= '0;
      req_write_value  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_sent         = 0;
      send_idle        = 0;
      recv_idle        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(hbs_pkg::OP_GET, 32'h0000_0001, 4'd0, 16'h0);
      write_defaults(64'hFFFF_FFFF_FFFF_FFFF);
      send(hbs_pkg::OP_GET, 32'h0, 4'd3, 16'h0);
      send(hbs_pkg::OP_GET, 32'h0, 4'd15, 16'h0);
      send(hbs_pkg::OP_GET, 32'h1234_5678, 4'd4, 16'h0);
      send(hbs_pkg::OP_SET, 32'hFFFF_FFFF, 4'd3, 16'hFFFF);
      send(hbs_pkg::OP_SET, 32'hFFFF_FFFF, 4'd0, 16'h0000);
      send(hbs_pkg::OP_GET, 32'hFFFF_FFFF, 4'd3, 16'h0);
      send(hbs_pkg::OP_GET, 32'hFFFF_FFFF, 4'd1, 16'h0);
      send(hbs_pkg::OP_SET, 32'h0, 4'd1, 16'h5555);
      send(hbs_pkg::OP_SET, 32'h0000_0001, 4'd4, 16'h5555);
      send(hbs_pkg::OP_SET, 32'h0000_0001, 4'd15, 16'hAAAA);
      send(hbs_pkg::OP_DROP, 32'h0, 4'd0, 16'h0);
      send(hbs_pkg::OP_DROP, 32'h0000_0002, 4'd0, 16'h0);
      send(2'd3, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
      send(hbs_pkg::OP_DROP, 32'hFFFF_FFFF, 4'd9, 16'h0);
      send(hbs_pkg::OP_GET, 32'hFFFF_FFFF, 4'd2, 16'h0);

      write_defaults(64'h0123_4567_89AB_CDEF);
      send_idle = 38;
      recv_idle = 62;
      random_beats(300);
      drain();
      send_idle = 62;
      recv_idle = 38;
      random_beats(150);
      drain();
      random_beats(150);
      write_defaults(64'($urandom()));
      send_idle = 0;
      recv_idle = 0;
      random_beats(200);
      write_defaults({$urandom(), $urandom()});
      fill_and_drain();
      write_defaults(64'h0);
      random_beats(100);

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d request beats and %0d response beats, incl. a full-table fill",
               req_sent, rsp_seen);
      $display("and drain, several default settings and three handshake stall mixes.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
